// ----- design/stp_pkg.sv -----
// Shared types, constants and character decoding for the timestamp parser.
package stp_pkg;

  localparam int unsigned ACC_W  = 32;
  localparam int unsigned K_W    = 10;
  localparam int unsigned PROD_W = ACC_W + K_W;
  localparam int unsigned TIME_W = 26;
  localparam int unsigned WGT_W  = 7;

  localparam logic [ACC_W-1:0]  ACC_SAT     = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0]  TIME_MAX_MS = ACC_W'(10 * 60 * 60 * 1000 - 6);
  localparam logic [K_W-1:0]    K_BASE60    = K_W'(60);
  localparam logic [K_W-1:0]    K_MS        = K_W'(1000);
  localparam logic [K_W-1:0]    K_DEC       = K_W'(10);
  localparam logic [WGT_W-1:0]  WGT_FIRST   = WGT_W'(100);
  localparam logic [WGT_W-1:0]  WGT_TENTH   = WGT_W'(10);
  localparam logic [WGT_W-1:0]  WGT_UNIT    = WGT_W'(1);

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_COLON,
    KIND_DOT,
    KIND_DIGIT
  } kind_t;

  typedef enum logic [1:0] {
    MUL_TOTAL60,
    MUL_TOTAL1000,
    MUL_FIELD10,
    MUL_DIGIT_W
  } mul_sel_t;

  typedef enum logic [1:0] {
    ADD_TOTAL_FIELD,
    ADD_FIELD_DIGIT,
    ADD_TOTAL_FRAC,
    ADD_TOTAL_ONLY
  } add_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     add_en;
    add_sel_t add_sel;
    logic     set_frac;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    kind_t in_kind;
    logic  in_last;
    kind_t kind_q;
    logic  last_q;
    logic  in_fraction;
    logic  out_free;
  } stat_t;

  function automatic kind_t char_kind(input logic [7:0] c, input logic v);
    kind_t k;
    k = KIND_NONE;
    if (v) begin
      if (c == CH_COLON) begin
        k = KIND_COLON;
      end else if (c == CH_DOT || c == CH_COMMA) begin
        k = KIND_DOT;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        k = KIND_DIGIT;
      end
    end
    return k;
  endfunction

endpackage

// ----- design/stp_datapath.sv -----
// Accumulators, shared constant multiplier, saturating adder and result register.
module stp_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 ch,
  input  logic                       ch_valid,
  input  logic                       last,
  input  stp_pkg::cmd_t              cmd,
  output stp_pkg::stat_t             stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [stp_pkg::TIME_W-1:0] time_ms
);
  import stp_pkg::*;

  logic [ACC_W-1:0]  total_acc;
  logic [ACC_W-1:0]  field_acc;
  logic              in_fraction;
  logic [WGT_W-1:0]  frac_weight;
  kind_t             kind_q;
  logic              last_q;
  logic [3:0]        digit_q;
  logic [PROD_W-1:0] prod;

  logic [ACC_W-1:0]  mul_a;
  logic [K_W-1:0]    mul_k;
  logic [ACC_W-1:0]  prod_sat;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  sum_sat;
  logic [WGT_W-1:0]  weight_next;

  // The digit value of an ASCII digit is its low nibble.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_TOTAL60: begin
        mul_a = total_acc;
        mul_k = K_BASE60;
      end
      MUL_TOTAL1000: begin
        mul_a = total_acc;
        mul_k = K_MS;
      end
      MUL_FIELD10: begin
        mul_a = field_acc;
        mul_k = K_DEC;
      end
      MUL_DIGIT_W: begin
        mul_a = ACC_W'(ch[3:0]);
        mul_k = K_W'(frac_weight);
      end
      default: begin
        mul_a = total_acc;
        mul_k = K_BASE60;
      end
    endcase
  end

  assign prod_sat = (prod[PROD_W-1:ACC_W] != '0) ? ACC_SAT : prod[ACC_W-1:0];

  always_comb begin
    unique case (cmd.add_sel)
      ADD_TOTAL_FIELD: addend = field_acc;
      ADD_FIELD_DIGIT: addend = ACC_W'(digit_q);
      ADD_TOTAL_FRAC:  addend = total_acc;
      ADD_TOTAL_ONLY:  addend = '0;
      default:         addend = '0;
    endcase
  end

  assign sum     = {1'b0, prod_sat} + {1'b0, addend};
  assign sum_sat = sum[ACC_W] ? ACC_SAT : sum[ACC_W-1:0];

  always_comb begin
    priority if (frac_weight == WGT_FIRST) begin
      weight_next = WGT_TENTH;
    end else if (frac_weight == WGT_TENTH) begin
      weight_next = WGT_UNIT;
    end else begin
      weight_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_k);
    end
    if (cmd.load) begin
      digit_q <= ch[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_acc   <= '0;
      field_acc   <= '0;
      in_fraction <= 1'b0;
      frac_weight <= '0;
      kind_q      <= KIND_NONE;
      last_q      <= 1'b0;
    end else begin
      if (cmd.load) begin
        kind_q <= char_kind(ch, ch_valid);
        last_q <= last;
      end
      if (cmd.out_load) begin
        total_acc   <= '0;
        field_acc   <= '0;
        in_fraction <= 1'b0;
        frac_weight <= '0;
      end else begin
        if (cmd.add_en) begin
          unique case (cmd.add_sel)
            ADD_TOTAL_FIELD: begin
              total_acc <= sum_sat;
              field_acc <= '0;
            end
            ADD_FIELD_DIGIT: field_acc <= sum_sat;
            ADD_TOTAL_FRAC: begin
              total_acc   <= sum_sat;
              frac_weight <= weight_next;
            end
            ADD_TOTAL_ONLY: total_acc <= sum_sat;
            default: total_acc <= sum_sat;
          endcase
        end
        if (cmd.set_frac) begin
          in_fraction <= 1'b1;
          frac_weight <= WGT_FIRST;
        end
      end
    end
  end

  // Result register; it holds a word until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      time_ms <= (total_acc > TIME_MAX_MS) ? TIME_MAX_MS[TIME_W-1:0] : total_acc[TIME_W-1:0];
    end
  end

  assign stat.in_kind     = char_kind(ch, ch_valid);
  assign stat.in_last     = last;
  assign stat.kind_q      = kind_q;
  assign stat.last_q      = last_q;
  assign stat.in_fraction = in_fraction;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

// ----- design/stp_ctrl.sv -----
// Sequencer that steps the datapath through multiply and add phases per character.
module stp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  stp_pkg::stat_t stat,
  output stp_pkg::cmd_t  cmd
);
  import stp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_FOLD_ADD = 11'b00000000010,
    S_K_MUL    = 11'b00000000100,
    S_K_ADD    = 11'b00000001000,
    S_DIG_ADD  = 11'b00000010000,
    S_FRAC_ADD = 11'b00000100000,
    S_END      = 11'b00001000000,
    S_E_ADD    = 11'b00010000000,
    S_E_KMUL   = 11'b00100000000,
    S_E_KADD   = 11'b01000000000,
    S_FINISH   = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_char;

  assign after_char = stat.last_q ? S_END : S_IDLE;
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (stat.in_kind)
            KIND_COLON, KIND_DOT: begin
              cmd.mul_en  = 1'b1;
              cmd.mul_sel = MUL_TOTAL60;
              state_next  = S_FOLD_ADD;
            end
            KIND_DIGIT: begin
              cmd.mul_en  = 1'b1;
              cmd.mul_sel = stat.in_fraction ? MUL_DIGIT_W : MUL_FIELD10;
              state_next  = stat.in_fraction ? S_FRAC_ADD : S_DIG_ADD;
            end
            default: begin
              state_next = stat.in_last ? S_END : S_IDLE;
            end
          endcase
        end
      end
      S_FOLD_ADD: begin
        cmd.add_en  = 1'b1;
        cmd.add_sel = ADD_TOTAL_FIELD;
        state_next  = (stat.kind_q == KIND_DOT) ? S_K_MUL : after_char;
      end
      S_K_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TOTAL1000;
        state_next  = S_K_ADD;
      end
      S_K_ADD: begin
        cmd.add_en   = 1'b1;
        cmd.add_sel  = ADD_TOTAL_ONLY;
        cmd.set_frac = 1'b1;
        state_next   = after_char;
      end
      S_DIG_ADD: begin
        cmd.add_en  = 1'b1;
        cmd.add_sel = ADD_FIELD_DIGIT;
        state_next  = after_char;
      end
      S_FRAC_ADD: begin
        cmd.add_en  = 1'b1;
        cmd.add_sel = ADD_TOTAL_FRAC;
        state_next  = after_char;
      end
      // Without a fraction the open field still has to be folded and scaled.
      S_END: begin
        if (stat.in_fraction) begin
          state_next = S_FINISH;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_TOTAL60;
          state_next  = S_E_ADD;
        end
      end
      S_E_ADD: begin
        cmd.add_en  = 1'b1;
        cmd.add_sel = ADD_TOTAL_FIELD;
        state_next  = S_E_KMUL;
      end
      S_E_KMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TOTAL1000;
        state_next  = S_E_KADD;
      end
      S_E_KADD: begin
        cmd.add_en  = 1'b1;
        cmd.add_sel = ADD_TOTAL_ONLY;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/subtitle_timestamp_parser_core.sv -----
// Top level of the timestamp text parser: controller plus datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   input    | in_valid / in_ready  | ch[7:0], ch_valid, last
//   output   | out_valid / out_ready| time_ms[25:0]
//
// A digit or colon word is a multiply then a saturating add through the one constant
// multiplier; a dot or comma adds a x1000 pair; an ignored character is just taken.
// A last word then runs S_END, without a fraction S_E_ADD to S_E_KADD, and S_FINISH.
// Reset clears all accumulators; they are cleared again after every result.
// A result waits in its own register; only a second result stalls on out_ready.
module subtitle_timestamp_parser_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 ch,
  input  logic                       ch_valid,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [stp_pkg::TIME_W-1:0] time_ms
);
  import stp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  stp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .ch_valid  (ch_valid),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .time_ms   (time_ms)
  );

endmodule
